// ===== rtl/core/prfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prfl_pkg
// Widths, sizes, reset values and register indexes of the page free list.
// ----------------------------------------------------------------------------
package prfl_pkg;

  localparam int unsigned NUM_REQUESTERS = 8;
  localparam int unsigned PAGE_SLOTS     = 32768;
  localparam int unsigned PAGE_SHIFT     = 12;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned SLOT_W = $clog2(PAGE_SLOTS);
  localparam int unsigned LIST_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int unsigned LINK_W = SLOT_W + 1;
  localparam int unsigned ALU_W  = ADDR_W + 2;

  localparam logic [ALU_W-1:0] PAGE_MASK = ALU_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  localparam logic [ADDR_W-1:0] POOL_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] POOL_STOP_RST  = 32'h8800_0000;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_STOP  = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/per_requester_page_free_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_requester_page_free_list
// Page allocator with one LIFO free list per requester, heads in flops and
// next links in a slot-indexed memory.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Every request
// gives one result, shown on the result ports for a single cycle with
// result_valid_o; the receiver cannot stall it. The sequencer drives a single
// shared 34-bit adder/subtractor: it first forms the page-rounded pool base,
// then a free runs three compares through it (pool start, pool stop, offset
// from base) and an allocate uses it once for the granted address while the
// next link is read from the link memory. A free reaching the slot check runs
// S_BASE, S_LO, S_HI and S_DIFF; one rejected earlier ends in S_BASE when
// misaligned, in S_LO below pool start and in S_HI at or above pool stop.
// An allocate finding a page runs S_BASE, S_POP and S_LINK, one finding none
// ends in S_BASE. The link memory needs no clearing after reset; configuration
// writes are taken only while the block is idle and start_i is low.
module per_requester_page_free_list (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  output logic                                  busy_o,
  input  wire                                   kind_i,
  input  wire  [prfl_pkg::REQ_W-1:0]            requester_i,
  input  wire  [prfl_pkg::ADDR_W-1:0]           page_address_i,
  output logic                                  result_valid_o,
  output logic                                  granted_o,
  output logic [prfl_pkg::ADDR_W-1:0]           granted_address_o,
  output logic                                  bad_free_o,
  output logic [prfl_pkg::REQ_W-1:0]            source_list_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [prfl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [prfl_pkg::ADDR_W-1:0]           cfg_data_i
);
  import prfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_LO,
    S_HI,
    S_DIFF,
    S_POP,
    S_LINK
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   pool_start_q;
  logic [ADDR_W-1:0]   pool_stop_q;
  logic                kind_q;
  logic [REQ_W-1:0]    req_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ALU_W-1:0]    base_q;
  logic [LIST_W-1:0]   src_q;
  logic [NUM_REQUESTERS-1:0] head_valid_q;
  logic [SLOT_W-1:0]   heads_q [NUM_REQUESTERS];

  logic                res_valid_q;
  logic                granted_q;
  logic [ADDR_W-1:0]   gaddr_q;
  logic                bad_q;
  logic [REQ_W-1:0]    src_out_q;

  logic [LINK_W-1:0]   link_mem [PAGE_SLOTS];
  logic [LINK_W-1:0]   link_rd_q;

  // shared adder
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ALU_W-1:0]    alu_res;

  logic [LIST_W-1:0]   req_idx;
  logic                req_ok;
  logic                own_ok;
  logic                any_ok;
  logic [LIST_W-1:0]   any_idx;
  logic                slot_ok;
  logic [SLOT_W-1:0]   new_slot;
  logic                mem_we;
  logic [LINK_W-1:0]   mem_wdata;

  assign req_idx  = LIST_W'(req_q);
  assign req_ok   = 32'(req_q) < NUM_REQUESTERS;
  assign own_ok   = req_ok && head_valid_q[req_idx];
  assign new_slot = alu_res[PAGE_SHIFT +: SLOT_W];
  assign slot_ok  = !alu_res[ALU_W-1] && (64'(alu_res >> PAGE_SHIFT) < 64'(PAGE_SLOTS));
  assign mem_we   = (state_q == S_DIFF) && slot_ok;
  assign mem_wdata = {head_valid_q[req_idx], heads_q[req_idx]};

  always_comb begin
    any_ok  = 1'b0;
    any_idx = '0;
    for (int i = NUM_REQUESTERS - 1; i >= 0; i--) begin
      if (head_valid_q[i]) begin
        any_ok  = 1'b1;
        any_idx = LIST_W'(i);
      end
    end
  end

  always_comb begin
    alu_a   = ALU_W'(addr_q);
    alu_b   = ALU_W'(pool_start_q);
    alu_sub = 1'b1;
    case (state_q)
      S_BASE: begin
        alu_a   = ALU_W'(pool_start_q);
        alu_b   = PAGE_MASK;
        alu_sub = 1'b0;
      end
      S_LO: begin
        alu_b = ALU_W'(pool_start_q);
      end
      S_HI: begin
        alu_b = ALU_W'(pool_stop_q);
      end
      S_DIFF: begin
        alu_b = base_q;
      end
      S_POP: begin
        alu_a   = base_q;
        alu_b   = ALU_W'(heads_q[src_q]) << PAGE_SHIFT;
        alu_sub = 1'b0;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
    alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[new_slot] <= mem_wdata;
    end
    if (state_q == S_POP) begin
      link_rd_q <= link_mem[heads_q[src_q]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pool_start_q <= POOL_START_RST;
      pool_stop_q  <= POOL_STOP_RST;
      kind_q       <= KIND_ALLOC;
      req_q        <= '0;
      addr_q       <= '0;
      base_q       <= '0;
      src_q        <= '0;
      head_valid_q <= '0;
      heads_q      <= '{default: '0};
      res_valid_q  <= 1'b0;
      granted_q    <= 1'b0;
      gaddr_q      <= '0;
      bad_q        <= 1'b0;
      src_out_q    <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_POOL_START: pool_start_q <= cfg_data_i;
          CFG_POOL_STOP:  pool_stop_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            kind_q  <= kind_i;
            req_q   <= requester_i;
            addr_q  <= page_address_i;
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          base_q <= alu_res & ~PAGE_MASK;
          if (kind_q == KIND_FREE) begin
            if (addr_q[PAGE_SHIFT-1:0] != '0 || !req_ok) begin
              res_valid_q <= 1'b1;
              granted_q   <= 1'b0;
              gaddr_q     <= '0;
              bad_q       <= 1'b1;
              src_out_q   <= '0;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_LO;
            end
          end else if (own_ok || any_ok) begin
            src_q   <= own_ok ? req_idx : any_idx;
            state_q <= S_POP;
          end else begin
            res_valid_q <= 1'b1;
            granted_q   <= 1'b0;
            gaddr_q     <= '0;
            bad_q       <= 1'b0;
            src_out_q   <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_LO: begin
          if (alu_res[ALU_W-1]) begin
            res_valid_q <= 1'b1;
            granted_q   <= 1'b0;
            gaddr_q     <= '0;
            bad_q       <= 1'b1;
            src_out_q   <= '0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_HI;
          end
        end
        S_HI: begin
          if (!alu_res[ALU_W-1]) begin
            res_valid_q <= 1'b1;
            granted_q   <= 1'b0;
            gaddr_q     <= '0;
            bad_q       <= 1'b1;
            src_out_q   <= '0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (slot_ok) begin
            head_valid_q[req_idx] <= 1'b1;
            heads_q[req_idx]      <= new_slot;
          end
          res_valid_q <= 1'b1;
          granted_q   <= 1'b0;
          gaddr_q     <= '0;
          bad_q       <= !slot_ok;
          src_out_q   <= '0;
          state_q     <= S_IDLE;
        end
        S_POP: begin
          gaddr_q <= alu_res[ADDR_W-1:0];
          state_q <= S_LINK;
        end
        S_LINK: begin
          head_valid_q[src_q] <= link_rd_q[LINK_W-1];
          heads_q[src_q]      <= link_rd_q[SLOT_W-1:0];
          res_valid_q <= 1'b1;
          granted_q   <= 1'b1;
          bad_q       <= 1'b0;
          src_out_q   <= REQ_W'(src_q);
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign cfg_ready_o       = !busy_o && !start_i;
  assign result_valid_o    = res_valid_q;
  assign granted_o         = granted_q;
  assign granted_address_o = gaddr_q;
  assign bad_free_o        = bad_q;
  assign source_list_o     = src_out_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted without going busy");

  a_grant_xor_bad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(granted_o && bad_free_o))
    else $error("result both granted and bad free");

  a_no_grant_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !granted_o |-> granted_address_o == '0 && source_list_o == '0)
    else $error("ungranted result carries an address or source");

  a_link_then_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINK |=> result_valid_o && granted_o && !busy_o)
    else $error("pop did not end in a granted result");

endmodule
`default_nettype wire
